FILE: hdl/k_qsb_pkg.sv
// ============================================================================
// k_qsb_pkg: shared types and constants for the k-queue shared buffer
// Table sizes, link encoding, request and status codes, controller types.
// ============================================================================
package k_qsb_pkg;

    // Sizes
    localparam int NUM_SLOTS   = 16;
    localparam int NUM_QUEUES  = 4;
    localparam int VALUE_WIDTH = 32;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int LINK_W = $clog2(NUM_SLOTS + 1);
    localparam int QID_W  = 2;

    // Null link: one past the last slot number
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_SLOTS);

    typedef logic [LINK_W-1:0] link_t;

    // Request codes
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_OVERFLOW  = 2'd1;
    localparam status_t STATUS_UNDERFLOW = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the request fields
        logic exec;   // update the tables and latch the result
    } ctrl_cmd_t;

    // A link names a real slot
    function automatic logic is_slot(input link_t x);
        return x < NULL_LINK;
    endfunction

endpackage

FILE: hdl/k_qsb_ctrl.sv
// ============================================================================
// k_qsb_ctrl: request sequencer
// Accepts one request, runs it through the datapath, holds the result.
// ============================================================================
module k_qsb_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output k_qsb_pkg::ctrl_cmd_t cmd
);
    import k_qsb_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_ready  = 1'b0;
        m_valid  = 1'b0;
        cmd.exec = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready  = 1'b1;
            ST_EXEC: cmd.exec = 1'b1;
            ST_RESP: m_valid  = 1'b1;
            default: s_ready  = 1'b0;
        endcase
        cmd.load = s_valid && s_ready;
    end

    // Never take a request while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while result pending");

    // A request always produces a result the cycle after it executes
    a_exec_to_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid)
        else $error("execute not followed by result");

    // A stalled result stays offered until the transfer
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped while stalled");

endmodule

FILE: hdl/k_qsb_datapath.sv
// ============================================================================
// k_qsb_datapath: queue tables, slot store and result registers
// Head/tail/link tables and free list in flops, values in a slot memory.
// ============================================================================
module k_qsb_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  k_qsb_pkg::ctrl_cmd_t        cmd,
    input  logic                        s_command,
    input  logic [k_qsb_pkg::QID_W-1:0] s_queue_id,
    input  logic signed [31:0]          s_value_in,
    output logic signed [31:0]          m_value_out,
    output k_qsb_pkg::status_t          m_status
);
    import k_qsb_pkg::*;

    // Captured request
    logic                   cmd_reg;
    logic [QID_W-1:0]       qid_reg;
    logic [VALUE_WIDTH-1:0] val_reg;

    // Queue tables and free list
    link_t links_reg [NUM_SLOTS];
    link_t heads_reg [NUM_QUEUES];
    link_t tails_reg [NUM_QUEUES];
    link_t free_head_reg;

    // Slot value store
    logic [VALUE_WIDTH-1:0] slot_mem [NUM_SLOTS];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    // Result
    status_t status_reg;
    logic    deq_ok_reg;

    // Execute-cycle decode
    logic              q_ok;
    link_t             head_q;
    link_t             tail_q;
    logic [SLOT_W-1:0] rd_addr;
    link_t             rd_link;
    logic              enq_ok;
    logic              deq_ok;
    status_t           status_next;

    always_comb begin
        q_ok    = int'(qid_reg) < NUM_QUEUES;
        head_q  = q_ok ? heads_reg[qid_reg] : NULL_LINK;
        tail_q  = q_ok ? tails_reg[qid_reg] : NULL_LINK;
        rd_addr = (cmd_reg == CMD_DEQUEUE) ? head_q[SLOT_W-1:0]
                                           : free_head_reg[SLOT_W-1:0];
        rd_link = links_reg[rd_addr];
        enq_ok  = (cmd_reg == CMD_ENQUEUE) && q_ok && is_slot(free_head_reg);
        deq_ok  = (cmd_reg == CMD_DEQUEUE) && q_ok && is_slot(head_q);
        if (cmd_reg == CMD_ENQUEUE) begin
            status_next = enq_ok ? STATUS_OK : STATUS_OVERFLOW;
        end else begin
            status_next = deq_ok ? STATUS_OK : STATUS_UNDERFLOW;
        end
    end

    // Request capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= s_command;
            qid_reg <= s_queue_id;
            val_reg <= VALUE_WIDTH'(s_value_in);
        end
    end

    // Link tables and free list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                links_reg[i] <= LINK_W'(i + 1);
            end
            for (int i = 0; i < NUM_QUEUES; i++) begin
                heads_reg[i] <= NULL_LINK;
                tails_reg[i] <= NULL_LINK;
            end
            free_head_reg <= '0;
        end else if (cmd.exec) begin
            if (enq_ok) begin
                // pop free list, append behind tail
                free_head_reg <= rd_link;
                if (!is_slot(head_q)) begin
                    heads_reg[qid_reg] <= free_head_reg;
                end else if (is_slot(tail_q)) begin
                    links_reg[tail_q[SLOT_W-1:0]] <= free_head_reg;
                end
                links_reg[free_head_reg[SLOT_W-1:0]] <= NULL_LINK;
                tails_reg[qid_reg] <= free_head_reg;
            end else if (deq_ok) begin
                // unlink head, push it on the free list
                heads_reg[qid_reg]            <= rd_link;
                links_reg[head_q[SLOT_W-1:0]] <= free_head_reg;
                free_head_reg                 <= head_q;
            end
        end
    end

    // Slot store: write on enqueue, registered read on dequeue
    always_ff @(posedge aclk) begin
        if (cmd.exec && enq_ok) begin
            slot_mem[free_head_reg[SLOT_W-1:0]] <= val_reg;
        end
        if (cmd.exec && deq_ok) begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    // Result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= STATUS_OK;
            deq_ok_reg <= 1'b0;
        end else if (cmd.exec) begin
            status_reg <= status_next;
            deq_ok_reg <= deq_ok;
        end
    end

    assign m_status    = status_reg;
    assign m_value_out = deq_ok_reg ? 32'(rd_data_reg) : '0;

    // Free head is a slot number or null, never beyond
    a_free_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        free_head_reg <= NULL_LINK)
        else $error("free head out of range");

    // A successful enqueue always moves the free head
    a_enq_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && enq_ok) |=> (free_head_reg != $past(free_head_reg)))
        else $error("enqueue did not pop the free list");

    // A successful dequeue returns its slot to the free list
    a_deq_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && deq_ok) |=> (free_head_reg == $past(head_q)))
        else $error("dequeue did not push the slot");

    // A dequeued value is only shown with an ok status
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        deq_ok_reg |-> (status_reg == STATUS_OK))
        else $error("dequeue data with error status");

endmodule

FILE: hdl/k_queues_shared_buffer_core.sv
// ============================================================================
// k_queues_shared_buffer_core: FIFO queues sharing one linked slot store
// Top level: request sequencer plus queue table datapath.
// ============================================================================
// Usage:
//   Input channel (s_valid/s_ready) carries one request: s_command selects
//   enqueue (s_value_in into queue s_queue_id) or dequeue (from s_queue_id).
//   Result channel (m_valid/m_ready) returns exactly one result per request:
//   m_value_out holds the dequeued value (0 on enqueue or error) and m_status
//   gives ok, overflow (no free slot) or underflow (queue empty).
//   Sequencing: a request accepted in the idle state is executed in the
//   execute state and its result is presented in the response state. One
//   request is in flight at a time; the three-state sequencer (accept,
//   execute, present) sets that order, with the execute cycle writing the
//   slot store or reading it into its registered read port.
//   Reset (aresetn low, synchronous) empties all queues and puts every slot
//   on the free list in order; no clearing pass is needed.
//   When the receiver stalls, the result is held unchanged on the m_ ports
//   and s_ready stays low until the result transfer completes.
// ============================================================================
module k_queues_shared_buffer_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_command,
    input  logic [k_qsb_pkg::QID_W-1:0] s_queue_id,
    input  logic signed [31:0]          s_value_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [31:0]          m_value_out,
    output k_qsb_pkg::status_t          m_status
);
    import k_qsb_pkg::*;

    ctrl_cmd_t cmd;

    // Sequencer
    k_qsb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Tables and slot store
    k_qsb_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_command   (s_command),
        .s_queue_id  (s_queue_id),
        .s_value_in  (s_value_in),
        .m_value_out (m_value_out),
        .m_status    (m_status)
    );

endmodule

FILE: test/tb_k_queues_shared_buffer_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_k_queues_shared_buffer_core: self-checking bench for the shared queues
// Drives enqueue and dequeue requests through the valid/ready request port
// and keeps its own copy of the slot store, link table, queue heads and tails
// and free list. Every request predicts one result, which is compared field
// by field with the next result transfer. A short directed pass covers value
// extremes, a full store and empty queues. Random bursts then fill and drain
// the store under several sender and receiver idling mixes.
// ============================================================================
module tb_k_queues_shared_buffer_core;
    import k_qsb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 350;
    localparam int TAIL_CYCLES    = 8;

    // DUT ports, inputs known from time zero
    logic               aclk       = 1'b0;
    logic               aresetn    = 1'b0;
    logic               s_valid    = 1'b0;
    logic               s_ready;
    logic               s_command  = CMD_ENQUEUE;
    logic [QID_W-1:0]   s_queue_id = '0;
    logic signed [31:0] s_value_in = '0;
    logic               m_valid;
    logic               m_ready    = 1'b0;
    logic signed [31:0] m_value_out;
    status_t            m_status;

    // Idling mix, in percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Shadow copy of the queue tables
    logic [VALUE_WIDTH-1:0] shadow_value [NUM_SLOTS];
    link_t                  shadow_next  [NUM_SLOTS];
    link_t                  shadow_head  [NUM_QUEUES];
    link_t                  shadow_tail  [NUM_QUEUES];
    link_t                  shadow_free;

    // Results still owed by the DUT, oldest first
    logic signed [31:0] owed_value  [$];
    status_t            owed_status [$];

    // Bookkeeping
    int errors       = 0;
    int n_enqueues   = 0;
    int n_dequeues   = 0;
    int n_overflows  = 0;
    int n_underflows = 0;
    int n_results    = 0;
    int stuck_cycles = 0;

    logic signed [31:0] want_value;
    status_t            want_status;

    k_queues_shared_buffer_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_queue_id  (s_queue_id),
        .s_value_in  (s_value_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value_out (m_value_out),
        .m_status    (m_status)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Shadow tables
    // ------------------------------------------------------------------------
    task automatic clear_queue_tables();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            shadow_value[i] = '0;
            shadow_next[i]  = link_t'(i + 1);
        end
        shadow_next[NUM_SLOTS-1] = NULL_LINK;
        for (int q = 0; q < NUM_QUEUES; q++) begin
            shadow_head[q] = NULL_LINK;
            shadow_tail[q] = NULL_LINK;
        end
        shadow_free = '0;
    endtask

    // Apply one request to the shadow tables and queue up its result
    task automatic apply_queue_op(input logic cmd, input logic [QID_W-1:0] qid,
                                  input logic signed [31:0] val);
        link_t              slot;
        logic signed [31:0] result;
        status_t            status;
        result = '0;
        status = STATUS_OK;
        if (cmd == CMD_ENQUEUE) begin
            n_enqueues++;
            if (int'(qid) >= NUM_QUEUES || shadow_free >= NULL_LINK) begin
                status = STATUS_OVERFLOW;
                n_overflows++;
            end else begin
                slot        = shadow_free;
                shadow_free = shadow_next[slot];
                if (shadow_head[qid] >= NULL_LINK) begin
                    shadow_head[qid] = slot;
                end else if (shadow_tail[qid] < NULL_LINK) begin
                    // append behind the tail; a stale tail on an empty queue is skipped
                    shadow_next[shadow_tail[qid]] = slot;
                end
                shadow_next[slot]  = NULL_LINK;
                shadow_tail[qid]   = slot;
                shadow_value[slot] = val;
            end
        end else begin
            n_dequeues++;
            if (int'(qid) >= NUM_QUEUES || shadow_head[qid] >= NULL_LINK) begin
                status = STATUS_UNDERFLOW;
                n_underflows++;
            end else begin
                slot             = shadow_head[qid];
                shadow_head[qid] = shadow_next[slot];
                shadow_next[slot] = shadow_free;
                shadow_free      = slot;
                result           = shadow_value[slot];
            end
        end
        owed_value.push_back(result);
        owed_status.push_back(status);
    endtask

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task automatic issue_request(input logic cmd, input logic [QID_W-1:0] qid,
                                 input logic signed [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_queue_id <= qid;
        s_value_in <= val;
        do @(posedge aclk); while (!s_ready);
        apply_queue_op(cmd, qid, val);
    endtask

    // Hold off new requests until every owed result has come back
    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (owed_status.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'sh0000_0000;
            1:       return 32'shFFFF_FFFF;
            2:       return 32'sh8000_0000;
            3:       return 32'sh7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls and the compare against the shadow
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (owed_status.size() == 0) begin
                errors++;
                $display("%0t: result with none owed: value %h status %0d",
                         $time, m_value_out, m_status);
            end else begin
                want_value  = owed_value.pop_front();
                want_status = owed_status.pop_front();
                if (m_status !== want_status) begin
                    errors++;
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want_status, m_status);
                end
                if (m_value_out !== want_value) begin
                    errors++;
                    $display("%0t: value_out mismatch: expected %h actual %h",
                             $time, want_value, m_value_out);
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
            $display("[k_queues_shared_buffer_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Value extremes, full store, empty queues and reuse of an emptied queue
    task automatic test_directed();
        logic signed [31:0] seed_vals [7];
        seed_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF,
                      32'sh0000_0001, 32'shAAAA_AAAA, 32'sh5555_5555};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // dequeue before anything was stored
        issue_request(CMD_DEQUEUE, 2'd1, 32'sh1234_5678);
        // fill every slot, round robin over the queues
        for (int i = 0; i < NUM_SLOTS; i++)
            issue_request(CMD_ENQUEUE, QID_W'(i % NUM_QUEUES),
                          (i < 7) ? seed_vals[i] : pick_value());
        // no free slot left
        issue_request(CMD_ENQUEUE, 2'd2, 32'sh0BAD_0BAD);
        // drain the last queue and go one past empty
        for (int i = 0; i < NUM_SLOTS / NUM_QUEUES + 1; i++)
            issue_request(CMD_DEQUEUE, 2'd3, pick_value());
        // emptied queue with a stale tail takes a new value
        issue_request(CMD_ENQUEUE, 2'd3, 32'sh0000_FFFF);
        issue_request(CMD_DEQUEUE, 2'd3, 32'sh0);
        wait_results_done();
    endtask

    // Random bursts that lean toward filling, draining or neither
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int               left;
        int               burst;
        int               enq_pct;
        int               focus;
        logic             cmd;
        logic [QID_W-1:0] qid;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        left = PHASE_ITEMS;
        while (left > 0) begin
            burst = $urandom_range(40, 8);
            if (burst > left)
                burst = left;
            case ($urandom_range(3))
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                2:       enq_pct = 50;
                default: enq_pct = 65;
            endcase
            focus = $urandom_range(NUM_QUEUES - 1);
            repeat (burst) begin
                qid = ($urandom_range(99) < 40) ? QID_W'(focus)
                                                : QID_W'($urandom_range(NUM_QUEUES - 1));
                cmd = ($urandom_range(99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
                issue_request(cmd, qid, pick_value());
            end
            left -= burst;
        end
        wait_results_done();
    endtask

    initial begin
        clear_queue_tables();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_traffic(0, 0);
        test_random_traffic(56, 0);
        test_random_traffic(0, 56);
        test_random_traffic(25, 25);

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d enqueues (%0d on a full store) and %0d dequeues (%0d on empty)",
                 n_enqueues, n_overflows, n_dequeues, n_underflows);
        $display("over four idling mixes; %0d results checked, %0d mismatches",
                 n_results, errors);
        if (errors == 0 && owed_status.size() == 0)
            $display("[k_queues_shared_buffer_core] OK");
        else
            $display("[k_queues_shared_buffer_core] ERROR");
        $finish;
    end

endmodule
